[sv/uart_modem_register_block_assert.svh]
// ---------------------------------------------------------------------------
// uart_modem_register_block_assert.svh
// Assertion macros for the UART register block checker.
// ---------------------------------------------------------------------------
`ifndef UART_MODEM_REGISTER_BLOCK_ASSERT_SVH
`define UART_MODEM_REGISTER_BLOCK_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define UMRB_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define UMRB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/umrb_pkg.sv]
// ---------------------------------------------------------------------------
// umrb_pkg
// Types and constants of the 16550-style UART register block.
// ---------------------------------------------------------------------------
package umrb_pkg;

	// Item kinds carried on the input tuser
	typedef enum logic [2:0] {
		KIND_BUS_READ  = 3'd0,
		KIND_BUS_WRITE = 3'd1,
		KIND_RX_BYTE   = 3'd2,
		KIND_MSR_CHG   = 3'd3,
		KIND_LSR_CHG   = 3'd4
	} kind_t;

	// Register offsets
	localparam logic [2:0] REG_RBR_THR = 3'd0;
	localparam logic [2:0] REG_IER     = 3'd1;
	localparam logic [2:0] REG_IIR_FCR = 3'd2;
	localparam logic [2:0] REG_LCR     = 3'd3;
	localparam logic [2:0] REG_MCR     = 3'd4;
	localparam logic [2:0] REG_LSR     = 3'd5;
	localparam logic [2:0] REG_MSR     = 3'd6;
	localparam logic [2:0] REG_SCR     = 3'd7;

	// IIR source codes (low nibble)
	localparam logic [3:0] IIR_MODEM   = 4'h0;
	localparam logic [3:0] IIR_NONE    = 4'h1;
	localparam logic [3:0] IIR_THRE    = 4'h2;
	localparam logic [3:0] IIR_RX_DATA = 4'h4;
	localparam logic [3:0] IIR_LINE    = 4'h6;

	// IER bits
	localparam logic [7:0] IER_RX    = 8'h01;
	localparam logic [7:0] IER_THRE  = 8'h02;
	localparam logic [7:0] IER_LINE  = 8'h04;
	localparam logic [7:0] IER_MODEM = 8'h08;

	// Misc masks and reset values
	localparam logic [7:0] LSR_ERR_MASK = 8'h1E;
	localparam logic [7:0] IIR_FIFO_ON  = 8'hC0;
	localparam logic [7:0] NOT_IMPL     = 8'hFF;
	localparam logic [7:0] IIR_RESET    = 8'h01;
	localparam logic [7:0] LSR_RESET    = 8'h60;
	localparam logic [7:0] MSR_RESET    = 8'h30;
	localparam logic [7:0] SCR_RESET    = 8'h01;

	// Controller to datapath commands
	typedef struct packed {
		logic load;   // latch the accepted input transaction
		logic exec;   // update registers and load the result register
	} umrb_cmd_t;

endpackage

[sv/umrb_ctrl.sv]
// ---------------------------------------------------------------------------
// umrb_ctrl
// Controller: input/output handshake and execute sequencing.
// ---------------------------------------------------------------------------
module umrb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output umrb_pkg::umrb_cmd_t cmd
);
	import umrb_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	// Take an item only when idle and the result register is free or draining
	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;

	assign cmd.load = s_tvalid && s_tready;
	assign cmd.exec = (state_q == ST_EXEC);

	// State and result-valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (out_valid_q && m_tready)
						out_valid_q <= 1'b0;
					if (s_tvalid && s_tready)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[sv/umrb_dp.sv]
// ---------------------------------------------------------------------------
// umrb_dp
// Datapath: UART registers, receive FIFO memory and result register.
// ---------------------------------------------------------------------------
module umrb_dp #(
	parameter int RX_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  umrb_pkg::umrb_cmd_t cmd,
	input  logic [2:0]          kind,
	input  logic [2:0]          reg_addr,
	input  logic [7:0]          wdata,
	input  logic [7:0]          rx_byte,
	input  logic [3:0]          msr_set,
	input  logic [3:0]          msr_clear,
	output logic [7:0]          rdata,
	output logic                tx_valid,
	output logic [7:0]          tx_byte,
	output logic                irq
);
	import umrb_pkg::*;

	localparam int IW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
	localparam int CW = $clog2(RX_DEPTH + 1);
	localparam int SW = IW + 1;

	// Drop the pending source when its code is pending and enabled
	function automatic logic [7:0] clr_src(logic [7:0] ier, logic [7:0] iir,
			logic [7:0] ier_bit, logic [3:0] code);
		logic [7:0] r;
		r = iir;
		if (((ier & ier_bit) != 8'h00) && (iir[3:0] == code))
			r = {iir[7:4], IIR_NONE};
		return r;
	endfunction

	// Latched input transaction
	kind_t      kind_q;
	logic [2:0] addr_q;
	logic [7:0] wdata_q;
	logic [7:0] rx_byte_q;
	logic [3:0] msr_set_q;
	logic [3:0] msr_clr_q;

	// Architectural registers
	logic [7:0] ier_q, dll_q, iir_q, lcr_q, mcr_q, lsr_q, msr_q, scr_q;
	logic [IW-1:0] head_q;
	logic [CW-1:0] count_q;

	// FIFO memory with registered read at the head
	logic [7:0]    mem [RX_DEPTH];
	logic [7:0]    rd_data_q;
	logic          push;
	logic [IW-1:0] wr_idx;
	logic [SW-1:0] wr_sum;

	// Next values
	logic [7:0]    ier_d, dll_d, iir_d, lcr_d, mcr_d, lsr_d, msr_d, scr_d;
	logic [IW-1:0] head_d;
	logic [CW-1:0] count_d;
	logic [7:0]    rdata_d, tx_byte_d;
	logic          tx_valid_d, irq_d;
	logic [3:0]    msr_hi, msr_chg;

	// Input latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= kind_t'(kind);
			addr_q    <= reg_addr;
			wdata_q   <= wdata;
			rx_byte_q <= rx_byte;
			msr_set_q <= msr_set;
			msr_clr_q <= msr_clear;
		end
	end

	// Push slot: (head + count) wrapped once
	assign wr_sum = SW'(head_q) + SW'(count_q);
	assign wr_idx = (wr_sum >= SW'(RX_DEPTH)) ? IW'(wr_sum - SW'(RX_DEPTH)) : IW'(wr_sum);
	assign push   = cmd.exec && (kind_q == KIND_RX_BYTE) && (count_q < CW'(RX_DEPTH));

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_idx] <= rx_byte_q;
		rd_data_q <= mem[head_q];
	end

	// Modem delta from the latched set/clear lines
	assign msr_hi  = msr_q[7:4];
	assign msr_chg = ((msr_hi ^ msr_set_q) & msr_set_q) | (msr_hi & msr_clr_q);

	// Execute: next register values and result
	always_comb begin
		ier_d      = ier_q;
		dll_d      = dll_q;
		iir_d      = iir_q;
		lcr_d      = lcr_q;
		mcr_d      = mcr_q;
		lsr_d      = lsr_q;
		msr_d      = msr_q;
		scr_d      = scr_q;
		head_d     = head_q;
		count_d    = count_q;
		rdata_d    = 8'h00;
		tx_byte_d  = 8'h00;
		tx_valid_d = 1'b0;
		irq_d      = 1'b0;
		unique case (kind_q)
			KIND_BUS_READ: begin
				unique case (addr_q)
					REG_RBR_THR: begin
						if (lcr_q[7]) begin
							rdata_d = dll_q;
						end else if (count_q != '0) begin
							rdata_d = rd_data_q;
							count_d = count_q - 1'b1;
							head_d  = (head_q == IW'(RX_DEPTH - 1)) ? '0 : head_q + 1'b1;
							if (count_d == '0) begin
								head_d = '0;
								lsr_d  = lsr_q & 8'hFE;
							end
							iir_d = clr_src(ier_q, iir_q, IER_RX, IIR_RX_DATA);
						end
					end
					REG_IER: rdata_d = NOT_IMPL;
					REG_IIR_FCR: begin
						iir_d   = clr_src(ier_q, iir_q, IER_THRE, IIR_THRE);
						rdata_d = iir_d;
					end
					REG_LCR: rdata_d = lcr_q;
					REG_MCR: rdata_d = mcr_q;
					REG_LSR: rdata_d = lsr_q;
					REG_MSR: begin
						iir_d   = clr_src(ier_q, iir_q, IER_MODEM, IIR_MODEM);
						rdata_d = msr_q;
						msr_d   = msr_q & 8'hF0;
					end
					REG_SCR: rdata_d = scr_q;
					default: rdata_d = NOT_IMPL;
				endcase
			end
			KIND_BUS_WRITE: begin
				unique case (addr_q)
					REG_RBR_THR: begin
						if (lcr_q[7]) begin
							dll_d = wdata_q;
						end else begin
							tx_valid_d = 1'b1;
							tx_byte_d  = wdata_q;
							iir_d      = clr_src(ier_q, iir_q, IER_THRE, IIR_THRE);
						end
					end
					// divisor high byte is write-only and has no effect here
					REG_IER: begin
						if (!lcr_q[7])
							ier_d = wdata_q;
					end
					// only the FIFO-enable bit is visible, through IIR
					REG_IIR_FCR: iir_d = wdata_q[0] ? (iir_q | IIR_FIFO_ON)
						: (iir_q & ~IIR_FIFO_ON);
					REG_LCR: lcr_d = wdata_q;
					REG_MCR: mcr_d = wdata_q;
					REG_SCR: scr_d = wdata_q;
					default: ;
				endcase
			end
			KIND_RX_BYTE: begin
				if (count_q < CW'(RX_DEPTH))
					count_d = count_q + 1'b1;
				// carrier detect raised, delta set on a rising edge
				msr_d = msr_q | 8'h80 | {4'h0, ~msr_q[7], 3'b000};
				lsr_d = lsr_q | 8'h01;
				iir_d = {iir_q[7:4], IIR_RX_DATA};
				irq_d = 1'b1;
			end
			KIND_MSR_CHG: begin
				if (ier_q[3] && (msr_chg != 4'h0)) begin
					iir_d = {iir_q[7:4], 4'h0};
					irq_d = 1'b1;
				end
				msr_d = (msr_q & ~{msr_clr_q, 4'h0}) | {msr_set_q, 4'h0} | {4'h0, msr_chg};
			end
			KIND_LSR_CHG: begin
				if (ier_q[2] && (((lsr_q ^ wdata_q) & wdata_q & LSR_ERR_MASK) != 8'h00)) begin
					iir_d = {iir_q[7:4], IIR_LINE};
					irq_d = 1'b1;
				end
				lsr_d = wdata_q;
			end
			default: ;
		endcase
	end

	// Register update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ier_q   <= 8'h00;
			dll_q   <= 8'h00;
			iir_q   <= IIR_RESET;
			lcr_q   <= 8'h00;
			mcr_q   <= 8'h00;
			lsr_q   <= LSR_RESET;
			msr_q   <= MSR_RESET;
			scr_q   <= SCR_RESET;
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			ier_q   <= ier_d;
			dll_q   <= dll_d;
			iir_q   <= iir_d;
			lcr_q   <= lcr_d;
			mcr_q   <= mcr_d;
			lsr_q   <= lsr_d;
			msr_q   <= msr_d;
			scr_q   <= scr_d;
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rdata    <= rdata_d;
			tx_valid <= tx_valid_d;
			tx_byte  <= tx_byte_d;
			irq      <= irq_d;
		end
	end

endmodule

[sv/uart_modem_register_block.sv]
// ---------------------------------------------------------------------------
// uart_modem_register_block
// 16550-style UART register file with receive FIFO, driven by a stream of
// bus accesses and line events, one result transaction per item.
// ---------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                               | tuser
// s_      | in  | reg_addr, wdata, rx_byte, msr_set, msr_clear     | kind
// m_      | out | rdata, tx_byte                                   | tx_valid, irq
//
// Each item passes the accept cycle and then the execute state, which is there
// for the registered read port of the receive FIFO memory.
// The result sits in an output register; the next item is accepted no earlier
// than the edge at which that result is taken, so a stalled result stalls input.
// arst_n clears the UART registers, the FIFO pointers and the controller; the
// memory, the input latch and the result register need no reset.
// ---------------------------------------------------------------------------
module uart_modem_register_block #(
	parameter int RX_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // reg_addr[2:0], wdata[10:3], rx_byte[18:11],
	                               // msr_set[22:19], msr_clear[26:23], zero above
	input  logic [2:0]  s_tuser,   // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // rdata[7:0], tx_byte[15:8]
	output logic [1:0]  m_tuser    // tx_valid[0], irq[1]
);
	import umrb_pkg::*;

	umrb_cmd_t  cmd;
	logic [7:0] rdata, tx_byte;
	logic       tx_valid, irq;

	umrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	umrb_dp #(
		.RX_DEPTH (RX_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.kind      (s_tuser),
		.reg_addr  (s_tdata[2:0]),
		.wdata     (s_tdata[10:3]),
		.rx_byte   (s_tdata[18:11]),
		.msr_set   (s_tdata[22:19]),
		.msr_clear (s_tdata[26:23]),
		.rdata     (rdata),
		.tx_valid  (tx_valid),
		.tx_byte   (tx_byte),
		.irq       (irq)
	);

	assign m_tdata = {tx_byte, rdata};
	assign m_tuser = {irq, tx_valid};

endmodule

[sv/umrb_chk.sv]
// ---------------------------------------------------------------------------
// umrb_chk
// Port-level checker for the UART register block, bound to the top level.
// ---------------------------------------------------------------------------
`include "uart_modem_register_block_assert.svh"

module umrb_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// Stalled result holds
	`UMRB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	// One item at a time: no accept right after an accept
	`UMRB_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "input accepted while busy")

	// Every accepted item shows its result once the execute state has run
	`UMRB_ASSERT_IMPL(a_result_latency, s_tvalid && s_tready, ##2 m_tvalid, "result missing after accept")

	// No transmit byte without a transmit
	`UMRB_ASSERT_IMPL(a_tx_byte_zero, m_tvalid && !m_tuser[0], m_tdata[15:8] == 8'h00, "tx_byte set without tx_valid")

	// A transmit write reads nothing and raises no interrupt
	`UMRB_ASSERT_IMPL(a_tx_only, m_tvalid && m_tuser[0], m_tdata[7:0] == 8'h00 && !m_tuser[1], "transmit result carries read data or irq")

endmodule

bind uart_modem_register_block umrb_chk u_umrb_chk (.*);
